/* design/pfuv_pkg.sv */
// Package for the planar face UV projection block.
// Holds the beat types, the plane codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfuv_pkg;

   // Fixed field widths of the interface.
   localparam int COORD_WIDTH = 24;
   localparam int SCALE_WIDTH = 24;
   localparam int TEX_WIDTH   = 32;

   // Texture scale after reset, 1.0 with eight fraction bits.
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 24'd256;

   // Projection plane codes. Code 3 never arises and reads as XY.
   typedef enum logic [1:0] {
      PLANE_XY = 2'd0,
      PLANE_YZ = 2'd1,
      PLANE_XZ = 2'd2
   } plane_type;

   // One vertex beat on the request channel.
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
      logic                          face_start;
      logic                          face_end;
   } vertex_type;

   // One UV beat on the response channel.
   typedef struct packed {
      logic signed [TEX_WIDTH-1:0] tex_u;
      logic signed [TEX_WIDTH-1:0] tex_v;
      logic                        saturated;
      logic                        run_last;
   } result_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_CROSS,
      ST_ABS,
      ST_PICK,
      ST_SETUP,
      ST_DIV_U,
      ST_FIN_U,
      ST_DIV_V,
      ST_FIN_V,
      ST_OUT
   } pfuv_state_type;

endpackage

`default_nettype wire

/* design/planar_face_uv_projection_top.sv */
// Top level of the planar face UV projection block.
// Depends on pfuv_pkg for the beat types, plane codes and states.
// Holds the sequencer, the shared multiplier and the shared restoring divider.
`timescale 1ns / 1ps
`default_nettype none

// Vertices of a face arrive one per request beat; the block takes one vertex at a
// time and drops req_stall only while idle. A vertex that releases no UV leaves the
// block idle. Both coordinates of each UV result go one after the other through a
// single restoring divider that retires one quotient bit per cycle, and a finished
// result is held while rsp_stall is high. On the third vertex of a face, one shared
// multiplier forms the six partial products of the face normal, and the block then
// releases three results. The texture scale register is always ready and should be
// written only while the block is idle.
module planar_face_uv_projection_top
   import pfuv_pkg::*;
#(
   parameter int COORD_FRACTION_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire vertex_type             req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output result_type                  rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [SCALE_WIDTH-1:0] csr_data
);

   // Dividend width, compare width for saturation and bit counter width.
   localparam int DW   = COORD_WIDTH + COORD_FRACTION_BITS;
   localparam int QX   = (DW > TEX_WIDTH + 1) ? DW : TEX_WIDTH + 1;
   localparam int CW   = $clog2(DW);
   localparam int DIFW = COORD_WIDTH + 1;
   localparam int PRW  = 2 * DIFW;
   localparam int NW   = PRW + 1;

   localparam logic [QX-1:0] NEG_LIM = QX'({1'b1, {(TEX_WIDTH-1){1'b0}}});
   localparam logic [QX-1:0] POS_LIM = QX'({1'b0, {(TEX_WIDTH-1){1'b1}}});

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } pos_type;

   function automatic logic signed [DIFW-1:0] sext_d(input logic signed [COORD_WIDTH-1:0] c);
      return {c[COORD_WIDTH-1], c};
   endfunction

   pfuv_state_type state_ff, state_in;
   logic [SCALE_WIDTH-1:0] scale_ff, scale_in;
   pos_type v0_ff, v0_in, v1_ff, v1_in, cur_ff, cur_in;
   logic [1:0] seen_ff, seen_in;
   plane_type plane_ff, plane_in;
   logic [1:0] nres_ff, nres_in;
   logic [1:0] ridx_ff, ridx_in;
   logic first_cur_ff, first_cur_in;
   logic signed [DIFW-1:0] a_ff [3];
   logic signed [DIFW-1:0] a_in [3];
   logic signed [DIFW-1:0] b_ff [3];
   logic signed [DIFW-1:0] b_in [3];
   logic [2:0] cstep_ff, cstep_in;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [NW-1:0] nrm_ff [3];
   logic signed [NW-1:0] nrm_in [3];
   logic [NW-1:0] nabs_ff [3];
   logic [NW-1:0] nabs_in [3];
   logic neg_u_ff, neg_u_in, neg_v_ff, neg_v_in;
   logic [COORD_WIDTH-1:0] magv_ff, magv_in;
   logic [SCALE_WIDTH-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [TEX_WIDTH-1:0] tex_u_ff, tex_u_in, tex_v_ff, tex_v_in;
   logic sat_ff, sat_in;

   // Helper signals shared by the next-state and datapath logic.
   logic [1:0] seen_eff;
   logic [1:0] acc_nres;
   logic run_last;
   pos_type sel_pos;
   logic signed [DIFW-1:0] du, dv;
   logic [DIFW-1:0] du_abs, dv_abs;
   logic signed [DIFW-1:0] mul_a, mul_b;
   logic [SCALE_WIDTH-1:0] div_val;
   logic [SCALE_WIDTH:0] r_ext, r_new;
   logic r_ge;
   logic [QX-1:0] qx;
   logic [TEX_WIDTH-1:0] tq;
   logic fin_neg, fin_over;
   logic signed [TEX_WIDTH-1:0] fin_val;

   // Configuration port takes a write in any cycle.
   assign csr_ready = 1'b1;

   // Vertex position within the face and the number of results it releases.
   always_comb begin
      seen_eff = req_data.face_start ? 2'd0 : seen_ff;
      unique case (seen_eff)
         2'd0: acc_nres = req_data.face_end ? 2'd1 : 2'd0;
         2'd1: acc_nres = req_data.face_end ? 2'd2 : 2'd0;
         2'd2: acc_nres = 2'd3;
         2'd3: acc_nres = 2'd1;
      endcase
   end

   assign run_last = (ridx_ff == (nres_ff - 2'd1));

   // Vertex of the current result and its offsets on the chosen plane.
   always_comb begin
      unique case (ridx_ff)
         2'd0:    sel_pos = first_cur_ff ? cur_ff : v0_ff;
         2'd1:    sel_pos = v1_ff;
         default: sel_pos = cur_ff;
      endcase
      unique case (plane_ff)
         PLANE_YZ: begin
            du = sext_d(sel_pos.y) - sext_d(v0_ff.y);
            dv = sext_d(sel_pos.z) - sext_d(v0_ff.z);
         end
         PLANE_XZ: begin
            du = sext_d(sel_pos.x) - sext_d(v0_ff.x);
            dv = sext_d(sel_pos.z) - sext_d(v0_ff.z);
         end
         default: begin
            du = sext_d(sel_pos.x) - sext_d(v0_ff.x);
            dv = sext_d(sel_pos.y) - sext_d(v0_ff.y);
         end
      endcase
      du_abs = du[DIFW-1] ? DIFW'(-du) : DIFW'(du);
      dv_abs = dv[DIFW-1] ? DIFW'(-dv) : DIFW'(dv);
   end

   // Operand selection for the shared multiplier over the six normal products.
   always_comb begin
      unique case (cstep_ff)
         3'd0:    begin mul_a = a_ff[1]; mul_b = b_ff[2]; end
         3'd1:    begin mul_a = a_ff[2]; mul_b = b_ff[1]; end
         3'd2:    begin mul_a = a_ff[2]; mul_b = b_ff[0]; end
         3'd3:    begin mul_a = a_ff[0]; mul_b = b_ff[2]; end
         3'd4:    begin mul_a = a_ff[0]; mul_b = b_ff[1]; end
         3'd5:    begin mul_a = a_ff[1]; mul_b = b_ff[0]; end
         default: begin mul_a = a_ff[0]; mul_b = b_ff[0]; end
      endcase
   end

   // One restoring divider step; a zero scale is taken as one LSB.
   always_comb begin
      div_val = (scale_ff == '0) ? SCALE_WIDTH'(1) : scale_ff;
      r_ext   = {rem_ff, quo_ff[DW-1]};
      r_ge    = (r_ext >= {1'b0, div_val});
      r_new   = r_ge ? (r_ext - {1'b0, div_val}) : r_ext;
   end

   // Sign and saturation of a finished quotient.
   always_comb begin
      fin_neg = (state_ff == ST_FIN_V) ? neg_v_ff : neg_u_ff;
      qx      = QX'(quo_ff);
      tq      = qx[TEX_WIDTH-1:0];
      if (fin_neg) begin
         fin_over = (qx > NEG_LIM);
         fin_val  = fin_over ? signed'(NEG_LIM[TEX_WIDTH-1:0]) : signed'(-tq);
      end else begin
         fin_over = (qx > POS_LIM);
         fin_val  = fin_over ? signed'(POS_LIM[TEX_WIDTH-1:0]) : signed'(tq);
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (seen_eff == 2'd2) begin
                  state_in = ST_DIFF;
               end else if (acc_nres != 2'd0) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_DIFF:  state_in = ST_CROSS;
         ST_CROSS: begin
            if (cstep_ff == 3'd6) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS:   state_in = ST_PICK;
         ST_PICK:  state_in = ST_SETUP;
         ST_SETUP: state_in = ST_DIV_U;
         ST_DIV_U: begin
            if (cnt_ff == '0) begin
               state_in = ST_FIN_U;
            end
         end
         ST_FIN_U: state_in = ST_DIV_V;
         ST_DIV_V: begin
            if (cnt_ff == '0) begin
               state_in = ST_FIN_V;
            end
         end
         ST_FIN_V: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = run_last ? ST_IDLE : ST_SETUP;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and bookkeeping updates for each state.
   always_comb begin
      scale_in     = csr_valid ? csr_data : scale_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      cur_in       = cur_ff;
      seen_in      = seen_ff;
      plane_in     = plane_ff;
      nres_in      = nres_ff;
      ridx_in      = ridx_ff;
      first_cur_in = first_cur_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cstep_in     = cstep_ff;
      prod_in      = prod_ff;
      nrm_in       = nrm_ff;
      nabs_in      = nabs_ff;
      neg_u_in     = neg_u_ff;
      neg_v_in     = neg_v_ff;
      magv_in      = magv_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      tex_u_in     = tex_u_ff;
      tex_v_in     = tex_v_ff;
      sat_in       = sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in       = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z};
               nres_in      = acc_nres;
               ridx_in      = 2'd0;
               cstep_in     = 3'd0;
               first_cur_in = (seen_eff == 2'd3);
               unique case (seen_eff)
                  2'd0: begin
                     v0_in    = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z};
                     plane_in = PLANE_XY;
                     seen_in  = 2'd1;
                  end
                  2'd1: begin
                     v1_in    = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z};
                     plane_in = PLANE_XY;
                     seen_in  = 2'd2;
                  end
                  2'd2:    seen_in = 2'd3;
                  2'd3:    seen_in = 2'd3;
               endcase
               if (req_data.face_end) begin
                  seen_in = 2'd0;
               end
            end
         end
         ST_DIFF: begin
            // Edge vectors from the first vertex.
            a_in[0] = sext_d(v1_ff.x) - sext_d(v0_ff.x);
            a_in[1] = sext_d(v1_ff.y) - sext_d(v0_ff.y);
            a_in[2] = sext_d(v1_ff.z) - sext_d(v0_ff.z);
            b_in[0] = sext_d(cur_ff.x) - sext_d(v0_ff.x);
            b_in[1] = sext_d(cur_ff.y) - sext_d(v0_ff.y);
            b_in[2] = sext_d(cur_ff.z) - sext_d(v0_ff.z);
         end
         ST_CROSS: begin
            // Multiply one pair per cycle and fold the previous product in.
            prod_in  = mul_a * mul_b;
            cstep_in = cstep_ff + 3'd1;
            unique case (cstep_ff)
               3'd1:    nrm_in[0] = NW'(prod_ff);
               3'd2:    nrm_in[0] = nrm_ff[0] - NW'(prod_ff);
               3'd3:    nrm_in[1] = NW'(prod_ff);
               3'd4:    nrm_in[1] = nrm_ff[1] - NW'(prod_ff);
               3'd5:    nrm_in[2] = NW'(prod_ff);
               3'd6:    nrm_in[2] = nrm_ff[2] - NW'(prod_ff);
               default: nrm_in    = nrm_ff;
            endcase
         end
         ST_ABS: begin
            for (int i = 0; i < 3; i++) begin
               nabs_in[i] = nrm_ff[i][NW-1] ? NW'(-nrm_ff[i]) : NW'(nrm_ff[i]);
            end
         end
         ST_PICK: begin
            // Z wins ties, then X over Y.
            if ((nabs_ff[2] >= nabs_ff[0]) && (nabs_ff[2] >= nabs_ff[1])) begin
               plane_in = PLANE_XY;
            end else if (nabs_ff[0] >= nabs_ff[1]) begin
               plane_in = PLANE_YZ;
            end else begin
               plane_in = PLANE_XZ;
            end
         end
         ST_SETUP: begin
            neg_u_in = du[DIFW-1];
            neg_v_in = dv[DIFW-1];
            magv_in  = dv_abs[COORD_WIDTH-1:0];
            quo_in   = DW'(du_abs[COORD_WIDTH-1:0]) << COORD_FRACTION_BITS;
            rem_in   = '0;
            cnt_in   = CW'(DW - 1);
         end
         ST_DIV_U, ST_DIV_V: begin
            rem_in = r_new[SCALE_WIDTH-1:0];
            quo_in = {quo_ff[DW-2:0], r_ge};
            cnt_in = cnt_ff - CW'(1);
         end
         ST_FIN_U: begin
            tex_u_in = fin_val;
            sat_in   = fin_over;
            quo_in   = DW'(magv_ff) << COORD_FRACTION_BITS;
            rem_in   = '0;
            cnt_in   = CW'(DW - 1);
         end
         ST_FIN_V: begin
            tex_v_in = fin_val;
            sat_in   = sat_ff | fin_over;
         end
         ST_OUT: begin
            if (!rsp_stall && !run_last) begin
               ridx_in = ridx_ff + 2'd1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Registers; control state is reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scale_ff <= SCALE_RESET;
         seen_ff  <= 2'd0;
         plane_ff <= PLANE_XY;
         nres_ff  <= 2'd0;
         ridx_ff  <= 2'd0;
         cstep_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         scale_ff <= scale_in;
         seen_ff  <= seen_in;
         plane_ff <= plane_in;
         nres_ff  <= nres_in;
         ridx_ff  <= ridx_in;
         cstep_ff <= cstep_in;
      end
      v0_ff        <= v0_in;
      v1_ff        <= v1_in;
      cur_ff       <= cur_in;
      first_cur_ff <= first_cur_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      prod_ff      <= prod_in;
      nrm_ff       <= nrm_in;
      nabs_ff      <= nabs_in;
      neg_u_ff     <= neg_u_in;
      neg_v_ff     <= neg_v_in;
      magv_ff      <= magv_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      tex_u_ff     <= tex_u_in;
      tex_v_ff     <= tex_v_in;
      sat_ff       <= sat_in;
   end

   // Channel outputs.
   always_comb begin
      req_stall          = (state_ff != ST_IDLE);
      rsp_valid          = (state_ff == ST_OUT);
      rsp_data.tex_u     = tex_u_ff;
      rsp_data.tex_v     = tex_v_ff;
      rsp_data.saturated = sat_ff;
      rsp_data.run_last  = run_last;
   end

endmodule

`default_nettype wire

/* design/pfuv_checker.sv */
// Port-level checker for the planar face UV projection block.
// Depends on pfuv_pkg for the beat types; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none

module pfuv_checker
   import pfuv_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire vertex_type req_data,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire result_type rsp_data
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // No vertex is taken while a result is pending.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request ready while a result is pending");

   // A vertex that closes a face always releases results, so the block goes busy.
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.face_end |=> req_stall)
      else $error("face end accepted without starting work");

   // A taken result beat is never shown again in the next cycle.
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result beat repeated");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind planar_face_uv_projection_top pfuv_checker u_pfuv_checker (.*);

`default_nettype wire
